/* rtl/hhfcs_pkg.sv */
// ----------------------------------------------------------------------------
// hhfcs_pkg
// Shared types and constants of the frame header hunter and channel scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package hhfcs_pkg;

  // Default frame geometry.
  localparam int unsigned DEF_CHANNELS    = 8;
  localparam int unsigned DEF_SAMPLE_BITS = 12;

  // Frame header bytes.
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  // Field widths of a result.
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned FRAME_NUM_W = 32;
  localparam int unsigned SCALED_W    = 30;
  localparam int unsigned CHAN_W      = 3;

  // Depth of the frame queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  // Register reset values: every gain is 1.0 in Q4.12, every offset is zero.
  localparam logic [63:0] GAIN_RESET   = 64'h1000_1000_1000_1000;
  localparam logic [63:0] OFFSET_RESET = 64'h0;

  // Register indexes.
  typedef enum logic [1:0] {
    REG_GAIN_LO = 2'd0,
    REG_GAIN_HI = 2'd1,
    REG_OFF_LO  = 2'd2,
    REG_OFF_HI  = 2'd3
  } reg_idx_e;

  // Scaling configuration handed to the back end.
  typedef struct packed {
    logic [63:0] gain_lo;
    logic [63:0] gain_hi;
    logic [63:0] off_lo;
    logic [63:0] off_hi;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/hhfcs_fifo.sv */
// ----------------------------------------------------------------------------
// hhfcs_fifo
// Short register queue holding complete frames between the front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hhfcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("frame queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("frame queue read while empty");
`endif

endmodule

`default_nettype wire

/* rtl/hhfcs_cfg.sv */
// ----------------------------------------------------------------------------
// hhfcs_cfg
// Register bank for per-channel gains and offsets behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module hhfcs_cfg import hhfcs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_lo <= GAIN_RESET;
      cfg_q.gain_hi <= GAIN_RESET;
      cfg_q.off_lo  <= OFFSET_RESET;
      cfg_q.off_hi  <= OFFSET_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_LO: cfg_q.gain_lo <= pwdata;
        REG_GAIN_HI: cfg_q.gain_hi <= pwdata;
        REG_OFF_LO:  cfg_q.off_lo  <= pwdata;
        REG_OFF_HI:  cfg_q.off_hi  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      REG_GAIN_LO: prdata = cfg_q.gain_lo;
      REG_GAIN_HI: prdata = cfg_q.gain_hi;
      REG_OFF_LO:  prdata = cfg_q.off_lo;
      REG_OFF_HI:  prdata = cfg_q.off_hi;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hhfcs_front.sv */
// ----------------------------------------------------------------------------
// hhfcs_front
// Header hunt and frame assembly; hands each finished frame to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hhfcs_front import hhfcs_pkg::*; #(
  parameter  int unsigned CHANNELS = DEF_CHANNELS,
  localparam int unsigned REC_W    = FRAME_NUM_W + WORD_W * CHANNELS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output logic      [REC_W-1:0] rec_o,
  input  wire logic             full_i
);

  localparam int unsigned DATA_BYTES = 2 * CHANNELS;
  localparam int unsigned CNT_W      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam int unsigned WIDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_HUNT  = 4'b0001,
    ST_SEEN  = 4'b0010,
    ST_DATA  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [FRAME_NUM_W-1:0]         frame_cnt_q, frame_cnt_d;
  logic [CHANNELS-1:0][WORD_W-1:0] words_q;
  logic                           accept;
  logic [WIDX_W-1:0]              widx;

  // The check byte waits while both queue slots hold frames.
  assign in_stall_o = (state_q == ST_CHECK) && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && (state_q == ST_CHECK);
  assign rec_o      = {frame_cnt_q + 1'b1, words_q};
  assign widx       = WIDX_W'(cnt_q >> 1);

  // Header hunt and byte position tracking.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    frame_cnt_d = frame_cnt_q;
    if (accept) begin
      case (state_q)
        ST_HUNT: begin
          if (rx_byte_i == HDR_FIRST) state_d = ST_SEEN;
        end
        ST_SEEN: begin
          // A repeated first header byte keeps the hunt at this point.
          if (rx_byte_i == HDR_SECOND) begin
            state_d = ST_DATA;
            cnt_d   = '0;
          end else if (rx_byte_i != HDR_FIRST) begin
            state_d = ST_HUNT;
          end
        end
        ST_DATA: begin
          if (cnt_q == CNT_W'(DATA_BYTES - 1)) begin
            state_d = ST_CHECK;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        ST_CHECK: begin
          // The check byte closes the frame whatever its value.
          state_d     = ST_HUNT;
          frame_cnt_d = frame_cnt_q + 1'b1;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      cnt_q       <= '0;
      frame_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      frame_cnt_q <= frame_cnt_d;
    end
  end

  // Data bytes land little-endian in the staging words.
  always_ff @(posedge clk_i) begin
    if (accept && (state_q == ST_DATA)) begin
      if (cnt_q[0]) begin
        words_q[widx][15:8] <= rx_byte_i;
      end else begin
        words_q[widx][7:0] <= rx_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/hhfcs_back.sv */
// ----------------------------------------------------------------------------
// hhfcs_back
// Per-channel scaling pipeline: issue and multiply, then offset add and output.
// ----------------------------------------------------------------------------
`default_nettype none

module hhfcs_back import hhfcs_pkg::*; #(
  parameter  int unsigned CHANNELS    = DEF_CHANNELS,
  parameter  int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int unsigned REC_W       = FRAME_NUM_W + WORD_W * CHANNELS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cfg_t                        cfg_i,
  input  wire logic [REC_W-1:0]            rec_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  output logic      [CHAN_W-1:0]           channel_o,
  output logic      [WORD_W-1:0]           raw_word_o,
  output logic signed [SCALED_W-1:0]       scaled_value_o,
  output logic      [FRAME_NUM_W-1:0]      frame_number_o,
  output logic                             last_of_frame_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PROD_W = SAMPLE_BITS + WORD_W;
  localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'((CHANNELS - 1) % 8);

  logic [CHANNELS-1:0][WORD_W-1:0] words;
  logic [FRAME_NUM_W-1:0]          frame_num;
  logic                            adv, issue, is_last;
  logic [CH_W-1:0]                 ch_q;
  logic [4:0]                      ch_wide;
  logic [CHAN_W-1:0]               ch3;
  logic [1:0]                      lane;
  logic [WORD_W-1:0]               word_sel, gain_sel, off_sel;

  // First stage registers.
  logic                   s1_valid_q;
  logic [CHAN_W-1:0]      s1_ch_q;
  logic [WORD_W-1:0]      s1_word_q;
  logic [PROD_W-1:0]      s1_prod_q;
  logic [WORD_W-1:0]      s1_off_q;
  logic [FRAME_NUM_W-1:0] s1_fn_q;
  logic                   s1_last_q;

  // Output stage registers.
  logic                   out_valid_q;
  logic [CHAN_W-1:0]      out_ch_q;
  logic [WORD_W-1:0]      out_word_q;
  logic [SCALED_W-1:0]    out_scaled_q;
  logic [FRAME_NUM_W-1:0] out_fn_q;
  logic                   out_last_q;
  logic [31:0]            off_ext, sum;

  assign words     = rec_i[WORD_W*CHANNELS-1:0];
  assign frame_num = rec_i[REC_W-1 -: FRAME_NUM_W];

  // The pipeline moves whenever the output slot is free or being taken.
  assign adv     = !out_valid_q || !out_stall_i;
  assign issue   = adv && !empty_i;
  assign is_last = (ch_q == CH_W'(CHANNELS - 1));
  assign pop_o   = issue && is_last;

  // Channels above seven reuse the lanes of channel modulo eight.
  assign ch_wide  = 5'(ch_q);
  assign ch3      = ch_wide[2:0];
  assign lane     = ch3[1:0];
  assign word_sel = words[ch_q];
  assign gain_sel = ch3[2] ? cfg_i.gain_hi[{lane, 4'b0000} +: WORD_W]
                           : cfg_i.gain_lo[{lane, 4'b0000} +: WORD_W];
  assign off_sel  = ch3[2] ? cfg_i.off_hi[{lane, 4'b0000} +: WORD_W]
                           : cfg_i.off_lo[{lane, 4'b0000} +: WORD_W];

  // Channel counter walks the frame at the queue head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        ch_q <= is_last ? '0 : ch_q + 1'b1;
      end
      if (adv) begin
        s1_valid_q  <= issue;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Sample times gain.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ch_q   <= ch3;
      s1_word_q <= word_sel;
      s1_prod_q <= PROD_W'(word_sel[SAMPLE_BITS-1:0]) * PROD_W'(gain_sel);
      s1_off_q  <= off_sel;
      s1_fn_q   <= frame_num;
      s1_last_q <= is_last;
    end
  end

  // Offset is an integer, so it enters above the twelve fraction bits.
  assign off_ext = {{4{s1_off_q[15]}}, s1_off_q, 12'b0};
  assign sum     = 32'(s1_prod_q) + off_ext;

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_ch_q     <= s1_ch_q;
      out_word_q   <= s1_word_q;
      out_scaled_q <= sum[SCALED_W-1:0];
      out_fn_q     <= s1_fn_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_o       = out_ch_q;
  assign raw_word_o      = out_word_q;
  assign scaled_value_o  = out_scaled_q;
  assign frame_number_o  = out_fn_q;
  assign last_of_frame_o = out_last_q;

`ifndef SYNTHESIS
  a_last_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_frame_o |-> channel_o == LAST_CH)
    else $error("frame end marked on a channel other than the last");
`endif

endmodule

`default_nettype wire

/* rtl/header_hunt_frame_channel_scaler_unit.sv */
// ----------------------------------------------------------------------------
// header_hunt_frame_channel_scaler_unit
// Byte-stream frame synchronizer with per-channel gain and offset scaling.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle and never stalls a byte except
// the check byte that closes a frame while two earlier frames still wait in
// the frame queue. A frame is 0x55 0xAA, 2*CHANNELS data bytes and one check
// byte; once the check byte is taken, the frame passes the queue, the first
// stage and the output stage, and its CHANNELS results follow one per
// cycle, limited only by the single scaling multiplier shared across channels
// and by out_stall_i. Gains are unsigned Q4.12 and offsets signed integers,
// both per channel, written over the APB port at byte addresses 0, 8, 16 and
// 24; change them only while no frame is in flight.
`default_nettype none

module header_hunt_frame_channel_scaler_unit import hhfcs_pkg::*; #(
  parameter int unsigned CHANNELS    = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready,
  // Byte input
  input  wire logic [7:0]              rx_byte_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  // Result output
  output logic      [CHAN_W-1:0]       channel_o,
  output logic      [WORD_W-1:0]       raw_word_o,
  output logic signed [SCALED_W-1:0]   scaled_value_o,
  output logic      [FRAME_NUM_W-1:0]  frame_number_o,
  output logic                         last_of_frame_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i
);

  localparam int unsigned REC_W = FRAME_NUM_W + WORD_W * CHANNELS;

  cfg_t             cfg;
  logic             push, pop, full, empty;
  logic [REC_W-1:0] push_rec, head_rec;

  // Configuration registers.
  hhfcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Header hunt and frame assembly.
  hhfcs_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .rec_o      (push_rec),
    .full_i     (full)
  );

  // Finished frames waiting for the scaler.
  hhfcs_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_rec),
    .empty_o     (empty)
  );

  // Per-channel scaling and result output.
  hhfcs_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .rec_i           (head_rec),
    .empty_i         (empty),
    .pop_o           (pop),
    .channel_o       (channel_o),
    .raw_word_o      (raw_word_o),
    .scaled_value_o  (scaled_value_o),
    .frame_number_o  (frame_number_o),
    .last_of_frame_o (last_of_frame_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

`default_nettype wire
